>>> src/assert_macros.svh
// Assertion macros shared by the Intel HEX record encoder.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ihx_pkg.sv
// Types and constants of the Intel HEX record encoder.
// No dependencies; used by ihx_ctrl, ihx_dp and the top level.
package ihx_pkg;

   localparam int CNT_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [0:0] REG_SEG_SHAMT = 1'b0;

   localparam logic [4:0] SEG_SHAMT_RESET = 5'd4;
   localparam logic [4:0] SEG_SHAMT_MAX   = 5'd16;
   localparam logic [4:0] LIN_SHIFT       = 5'd16;
   localparam logic [32:0] SEG_SPAN       = 33'h10000;

   localparam logic OP_DATA   = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic [7:0] ADDR_REC_LEN = 8'h02;
   localparam logic [7:0] REC_TYPE_EOF = 8'h01;
   localparam logic [7:0] REC_TYPE_SEG = 8'h02;
   localparam logic [7:0] REC_TYPE_LIN = 8'h04;

   typedef enum logic [3:0] {
      SEL_ZERO,
      SEL_ADDR_LEN,
      SEL_TYPE,
      SEL_SEG_HI,
      SEL_SEG_LO,
      SEL_CNT,
      SEL_OFF_HI,
      SEL_OFF_LO,
      SEL_DATA,
      SEL_EOF_TYPE,
      SEL_CHK
   } ihx_sel_type;

   typedef struct packed {
      logic        op;
      logic [31:0] byte_addr;
      logic [7:0]  data_byte;
   } ihx_req_type;

   typedef struct packed {
      logic [7:0] rec_byte;
      logic       rec_start;
      logic       rec_end;
      logic       last;
   } ihx_rsp_type;

   typedef struct packed {
      logic             load_item;
      logic             set_line;
      logic             clr_fill;
      logic             store;
      logic             adv_line;
      logic             mode_chk;
      logic             seg_diff;
      logic             seg_load;
      logic             off_calc;
      logic             clear_all;
      logic             emit;
      ihx_sel_type      sel;
      logic             start;
      logic             stop;
      logic             last;
      logic [CNT_W-1:0] rd_addr;
   } ihx_cmd_type;

   typedef struct packed {
      logic             cont;
      logic             fill_zero;
      logic             full_next;
      logic             need_seg;
      logic             out_free;
      logic [CNT_W-1:0] fill;
   } ihx_status_type;

endpackage

>>> src/ihx_ctrl.sv
// Controller of the Intel HEX record encoder: sequences item handling and
// record emission. Depends on ihx_pkg; drives the datapath ihx_dp.
module ihx_ctrl #(
   parameter int LINE_BYTES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_op,
   output logic                       req_stall,
   input  ihx_pkg::ihx_status_type    st,
   output ihx_pkg::ihx_cmd_type       cmd
);

   localparam int DW = $clog2(LINE_BYTES + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONT,
      ST_STORE,
      ST_MODE,
      ST_DIFF,
      ST_SEG,
      ST_ADDR_REC,
      ST_OFF,
      ST_HDR,
      ST_DATA,
      ST_CHK,
      ST_END
   } state_type;

   typedef enum logic [1:0] {
      KIND_PRE,
      KIND_FULL,
      KIND_FIN
   } wr_kind_type;

   state_type   state_ff, state_in;
   wr_kind_type kind_ff, kind_in;
   logic [2:0]  idx_ff, idx_in;
   logic [DW-1:0] d_ff, d_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      idx_in   = idx_ff;
      d_in     = d_ff;
      cmd      = '0;
      cmd.sel  = ihx_pkg::SEL_ZERO;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (req_op == ihx_pkg::OP_FINISH) begin
                  if (st.fill_zero) begin
                     idx_in   = 3'd0;
                     state_in = ST_END;
                  end else begin
                     kind_in  = KIND_FIN;
                     state_in = ST_MODE;
                  end
               end else begin
                  state_in = ST_CONT;
               end
            end
         end
         ST_CONT: begin
            if (!st.cont) begin
               if (st.fill_zero) begin
                  cmd.set_line = 1'b1;
                  state_in     = ST_STORE;
               end else begin
                  kind_in  = KIND_PRE;
                  state_in = ST_MODE;
               end
            end else begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (st.full_next) begin
               kind_in  = KIND_FULL;
               state_in = ST_MODE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MODE: begin
            cmd.mode_chk = 1'b1;
            state_in     = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.seg_diff = 1'b1;
            state_in     = ST_SEG;
         end
         ST_SEG: begin
            if (st.need_seg) begin
               cmd.seg_load = 1'b1;
               idx_in       = 3'd0;
               state_in     = ST_ADDR_REC;
            end else begin
               state_in = ST_OFF;
            end
         end
         ST_ADDR_REC: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               idx_in   = idx_ff + 3'd1;
               case (idx_ff) inside
                  3'd0: begin
                     cmd.sel   = ihx_pkg::SEL_ADDR_LEN;
                     cmd.start = 1'b1;
                  end
                  3'd1, 3'd2: cmd.sel = ihx_pkg::SEL_ZERO;
                  3'd3: cmd.sel = ihx_pkg::SEL_TYPE;
                  3'd4: cmd.sel = ihx_pkg::SEL_SEG_HI;
                  3'd5: cmd.sel = ihx_pkg::SEL_SEG_LO;
                  default: begin
                     cmd.sel  = ihx_pkg::SEL_CHK;
                     cmd.stop = 1'b1;
                     state_in = ST_OFF;
                  end
               endcase
            end
         end
         ST_OFF: begin
            cmd.off_calc = 1'b1;
            idx_in       = 3'd0;
            state_in     = ST_HDR;
         end
         ST_HDR: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               idx_in   = idx_ff + 3'd1;
               case (idx_ff)
                  3'd0: begin
                     cmd.sel   = ihx_pkg::SEL_CNT;
                     cmd.start = 1'b1;
                  end
                  3'd1: cmd.sel = ihx_pkg::SEL_OFF_HI;
                  3'd2: cmd.sel = ihx_pkg::SEL_OFF_LO;
                  default: begin
                     cmd.sel  = ihx_pkg::SEL_ZERO;
                     d_in     = '0;
                     state_in = ST_DATA;
                  end
               endcase
            end
         end
         ST_DATA: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = ihx_pkg::SEL_DATA;
               d_in     = d_ff + DW'(1);
               if ((ihx_pkg::CNT_W'(d_ff) + ihx_pkg::CNT_W'(1)) == st.fill) begin
                  state_in = ST_CHK;
               end
            end
         end
         ST_CHK: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = ihx_pkg::SEL_CHK;
               cmd.stop = 1'b1;
               case (kind_ff)
                  KIND_PRE: begin
                     // a one-byte line fills again at once and writes once more
                     cmd.last     = (LINE_BYTES != 1);
                     cmd.set_line = 1'b1;
                     cmd.clr_fill = 1'b1;
                     state_in     = ST_STORE;
                  end
                  KIND_FULL: begin
                     cmd.last     = 1'b1;
                     cmd.adv_line = 1'b1;
                     state_in     = ST_IDLE;
                  end
                  default: begin
                     cmd.clr_fill = 1'b1;
                     idx_in       = 3'd0;
                     state_in     = ST_END;
                  end
               endcase
            end
         end
         ST_END: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               idx_in   = idx_ff + 3'd1;
               case (idx_ff) inside
                  3'd0: begin
                     cmd.sel   = ihx_pkg::SEL_ZERO;
                     cmd.start = 1'b1;
                  end
                  3'd1, 3'd2: cmd.sel = ihx_pkg::SEL_ZERO;
                  3'd3: cmd.sel = ihx_pkg::SEL_EOF_TYPE;
                  default: begin
                     cmd.sel       = ihx_pkg::SEL_CHK;
                     cmd.stop      = 1'b1;
                     cmd.last      = 1'b1;
                     cmd.clear_all = 1'b1;
                     state_in      = ST_IDLE;
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // read one entry ahead so the buffer data is ready when emitted
      cmd.rd_addr = ihx_pkg::CNT_W'(d_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= KIND_PRE;
         idx_ff   <= 3'd0;
         d_ff     <= '0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         idx_ff   <= idx_in;
         d_ff     <= d_in;
      end
   end

endmodule

>>> src/ihx_dp.sv
// Datapath of the Intel HEX record encoder: line buffer, address state,
// segment arithmetic, record byte mux, output register and CSR. Uses ihx_pkg.
module ihx_dp #(
   parameter int LINE_BYTES = 16,
   parameter int ADDR_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ihx_pkg::ihx_req_type                req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ihx_pkg::ihx_rsp_type                rsp_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ihx_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ihx_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ihx_pkg::CSR_DATA_W-1:0]      csr_prdata,
   input  ihx_pkg::ihx_cmd_type                cmd,
   output ihx_pkg::ihx_status_type             st
);

   localparam int AW = ADDR_BITS;
   localparam int IW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

   logic [4:0]                seg_shamt_ff, seg_shamt_in;
   logic [AW-1:0]             line_addr_ff, line_addr_in;
   logic [ihx_pkg::CNT_W-1:0] fill_ff, fill_in;
   logic [15:0]               seg_ff, seg_in;
   logic                      linear_ff, linear_in;
   logic [AW-1:0]             addr_ff;
   logic [7:0]                data_ff;
   logic [32:0]               diff_ff;
   logic [15:0]               off_ff;
   logic [7:0]                sum_ff;
   logic [7:0]                rd_data_ff;
   logic [7:0]                line_mem_ff [LINE_BYTES];
   logic                      rsp_valid_ff, rsp_valid_in;
   ihx_pkg::ihx_rsp_type      rsp_ff;

   logic [4:0]  sh_eff;
   logic [4:0]  sh_mode;
   logic [32:0] base33;
   logic [32:0] cnt33;
   logic [32:0] seg_base33;
   logic [7:0]  out_byte;
   logic        csr_wr;
   logic        csr_hit;

   assign sh_eff     = (seg_shamt_ff > ihx_pkg::SEG_SHAMT_MAX) ? ihx_pkg::SEG_SHAMT_MAX
                                                               : seg_shamt_ff;
   assign sh_mode    = linear_ff ? ihx_pkg::LIN_SHIFT : sh_eff;
   assign base33     = 33'(line_addr_ff);
   assign cnt33      = 33'(fill_ff);
   assign seg_base33 = 33'(seg_ff) << sh_mode;

   assign csr_hit    = (csr_paddr[ihx_pkg::CSR_ADDR_W-1:2] == ihx_pkg::REG_SEG_SHAMT);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_prdata = csr_hit ? ihx_pkg::CSR_DATA_W'(seg_shamt_ff) : '0;

   assign st.cont      = (addr_ff == (line_addr_ff + AW'(fill_ff)));
   assign st.fill_zero = (fill_ff == '0);
   assign st.full_next = ((fill_ff + ihx_pkg::CNT_W'(1)) >= ihx_pkg::CNT_W'(LINE_BYTES));
   assign st.need_seg  = diff_ff[32] ||
                         ((33'(diff_ff[31:0]) + cnt33) > ihx_pkg::SEG_SPAN);
   assign st.out_free  = !rsp_valid_ff || !rsp_stall;
   assign st.fill      = fill_ff;

   always_comb begin
      case (cmd.sel)
         ihx_pkg::SEL_ADDR_LEN: out_byte = ihx_pkg::ADDR_REC_LEN;
         ihx_pkg::SEL_TYPE:     out_byte = linear_ff ? ihx_pkg::REC_TYPE_LIN
                                                     : ihx_pkg::REC_TYPE_SEG;
         ihx_pkg::SEL_SEG_HI:   out_byte = seg_ff[15:8];
         ihx_pkg::SEL_SEG_LO:   out_byte = seg_ff[7:0];
         ihx_pkg::SEL_CNT:      out_byte = 8'(fill_ff);
         ihx_pkg::SEL_OFF_HI:   out_byte = off_ff[15:8];
         ihx_pkg::SEL_OFF_LO:   out_byte = off_ff[7:0];
         ihx_pkg::SEL_DATA:     out_byte = rd_data_ff;
         ihx_pkg::SEL_EOF_TYPE: out_byte = ihx_pkg::REC_TYPE_EOF;
         ihx_pkg::SEL_CHK:      out_byte = 8'h00 - sum_ff;
         default:               out_byte = 8'h00;
      endcase
   end

   always_comb begin
      seg_shamt_in = seg_shamt_ff;
      line_addr_in = line_addr_ff;
      fill_in      = fill_ff;
      seg_in       = seg_ff;
      linear_in    = linear_ff;
      rsp_valid_in = rsp_valid_ff;
      if (csr_wr) begin
         seg_shamt_in = csr_pwdata[4:0];
      end
      if (cmd.set_line) begin
         line_addr_in = addr_ff;
      end
      if (cmd.clr_fill) begin
         fill_in = '0;
      end
      if (cmd.store) begin
         fill_in = fill_ff + ihx_pkg::CNT_W'(1);
      end
      if (cmd.adv_line) begin
         line_addr_in = line_addr_ff + AW'(LINE_BYTES);
         fill_in      = '0;
      end
      // leave segmented mode, until a finish or reset, once the line passes its range
      if (cmd.mode_chk && !linear_ff &&
          ((base33 + cnt33) >= (ihx_pkg::SEG_SPAN << sh_eff))) begin
         linear_in = 1'b1;
         seg_in    = '0;
      end
      if (cmd.seg_load) begin
         seg_in = 16'(base33 >> sh_mode);
      end
      if (cmd.clear_all) begin
         line_addr_in = '0;
         fill_in      = '0;
         seg_in       = '0;
         linear_in    = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_shamt_ff <= ihx_pkg::SEG_SHAMT_RESET;
         line_addr_ff <= '0;
         fill_ff      <= '0;
         seg_ff       <= '0;
         linear_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_shamt_ff <= seg_shamt_in;
         line_addr_ff <= line_addr_in;
         fill_ff      <= fill_in;
         seg_ff       <= seg_in;
         linear_ff    <= linear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         addr_ff <= req_payload.byte_addr[AW-1:0];
         data_ff <= req_payload.data_byte;
      end
      if (cmd.seg_diff) begin
         diff_ff <= base33 - seg_base33;
      end
      if (cmd.off_calc) begin
         off_ff <= line_addr_ff[15:0] - seg_base33[15:0];
      end
      if (cmd.emit) begin
         sum_ff         <= cmd.start ? out_byte : sum_ff + out_byte;
         rsp_ff.rec_byte  <= out_byte;
         rsp_ff.rec_start <= cmd.start;
         rsp_ff.rec_end   <= cmd.stop;
         rsp_ff.last      <= cmd.last;
      end
   end

   // line buffer: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         line_mem_ff[fill_ff[IW-1:0]] <= data_ff;
      end
      if (cmd.rd_addr < ihx_pkg::CNT_W'(LINE_BYTES)) begin
         rd_data_ff <= line_mem_ff[cmd.rd_addr[IW-1:0]];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> src/intel_hex_record_encoder_top.sv
// Top level of the Intel HEX record encoder: joins controller and datapath.
// Depends on ihx_pkg, ihx_ctrl, ihx_dp and assert_macros.svh.
//
// Usage: data items (op 0) carry a linear byte address and a data byte; a
// finish item (op 1) flushes the line buffer and sends the end record.
// Results are binary record bytes, one per transfer on rsp_, with rec_start on
// the count byte, rec_end on the checksum and last on the final byte that an
// item causes. req_stall stays high while an item is being worked on; one
// item is handled at a time.
// Sequence: a data item that writes no record passes the continuity check and
// the store before the next accept. A line write adds address work (mode
// check, segment difference, segment decision), an optional segment or
// linear record, the offset step, then a record of N data bytes, one record
// byte per cycle from the output register while the receiver does not stall.
// A finish adds the end record.
// Reset (synchronous, active high) empties the buffer, selects segmented
// mode with segment 0 and sets the segment shift to 4; a finish does the same
// but keeps the shift. When the receiver stalls, the pending byte holds in the
// output register and record emission waits. The shift is at CSR address 0.
`include "assert_macros.svh"

module intel_hex_record_encoder_top #(
   parameter int LINE_BYTES = 16,
   parameter int ADDR_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ihx_pkg::ihx_req_type                req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ihx_pkg::ihx_rsp_type                rsp_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ihx_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ihx_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ihx_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   ihx_pkg::ihx_cmd_type    cmd;
   ihx_pkg::ihx_status_type st;
   logic                    rsp_last;

   assign csr_pready = 1'b1;
   assign rsp_last   = rsp_valid && rsp_payload.last;

   ihx_ctrl #(
      .LINE_BYTES (LINE_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.op),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   ihx_dp #(
      .LINE_BYTES (LINE_BYTES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cmd         (cmd),
      .st          (st)
   );

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "not busy")
   `ASSERT_IMPLIES(a_no_emit_full, clock, reset, !st.out_free, !cmd.emit, "emit while stalled")
   `ASSERT_IMPLIES(a_last_end, clock, reset, rsp_last, rsp_payload.rec_end, "last without rec_end")
   `ASSERT_IMPLIES(a_emit_while_busy, clock, reset, cmd.emit, req_stall, "emit while idle")

endmodule
